FILE: hdl/assert_macros.svh
// Assertion macros shared by the echo confirm link sender RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/ecls_pkg.sv
// Types, codes and helpers shared by the echo confirm link sender.
`timescale 1ns / 1ps
`default_nettype none

package ecls_pkg;

    // event kinds
    localparam logic [1:0] OP_HOST   = 2'd0;
    localparam logic [1:0] OP_DONE   = 2'd1;
    localparam logic [1:0] OP_PACKET = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    // result actions
    localparam logic [2:0] ACT_SEND     = 3'd0;
    localparam logic [2:0] ACT_RX       = 3'd1;
    localparam logic [2:0] ACT_CONFIRM  = 3'd2;
    localparam logic [2:0] ACT_ACK      = 3'd3;
    localparam logic [2:0] ACT_GET      = 3'd4;
    localparam logic [2:0] ACT_MISMATCH = 3'd5;
    localparam logic [2:0] ACT_REJECT   = 3'd6;
    localparam logic [2:0] ACT_TIMEOUT  = 3'd7;

    localparam logic [7:0]  GET_MARK      = 8'hFF;
    localparam logic [7:0]  CODE_OK       = 8'hAA;
    localparam logic [7:0]  CODE_BAD      = 8'hFF;
    localparam logic [7:0]  MIN_ECHO_LEN  = 8'd2;
    localparam logic [1:0]  CNT_COMMAND   = 2'd2;
    localparam logic [1:0]  CNT_CONFIRM   = 2'd1;
    localparam logic [1:0]  CNT_NONE      = 2'd0;
    localparam logic [15:0] TIMEOUT_RESET = 16'd200;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] command_byte;
        logic [7:0] value_byte;
        logic [7:0] echo_first;
        logic [7:0] echo_second;
        logic [7:0] packet_length;
        logic       read_good;
    } t_in_item;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [1:0] byte_count;
        logic       last;
    } t_out_item;

    // all results of one request
    typedef struct packed {
        logic      two;
        t_out_item res0;
        t_out_item res1;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    function automatic t_out_item mk_res(input logic [2:0] act, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [1:0] cnt,
                                         input logic last);
        t_out_item r;
        r.action     = act;
        r.byte_one   = b1;
        r.byte_two   = b2;
        r.byte_count = cnt;
        r.last       = last;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ecls_front.sv
// Front end: accepts events, runs the link state machine, queues results.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ecls_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire ecls_pkg::t_in_item i_item,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [15:0]       i_cfg_wr_data,
    output ecls_pkg::t_push        o_push
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_TX      = 4'b0010,
        PH_ECHO    = 4'b0100,
        PH_CONFIRM = 4'b1000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_held_cmd, n_held_cmd;
    logic [7:0]  r_held_val, n_held_val;
    logic        r_is_get, n_is_get;
    logic        r_matched, n_matched;
    logic [7:0]  r_answer, n_answer;
    logic [15:0] r_elapsed, n_elapsed;
    logic [15:0] r_timeout;

    logic [15:0] elapsed_inc;
    logic        match_now;
    logic        get_now;
    ecls_pkg::t_out_item send_res;

    assign elapsed_inc = (r_elapsed == ecls_pkg::TICKS_MAX) ? r_elapsed
                                                            : r_elapsed + 16'd1;
    assign get_now     = (r_held_val == ecls_pkg::GET_MARK);
    assign match_now   = get_now ? (i_item.echo_first == r_held_cmd)
                                 : ((i_item.echo_first == r_held_cmd) &&
                                    (i_item.echo_second == r_held_val));
    assign send_res    = ecls_pkg::mk_res(ecls_pkg::ACT_SEND, r_held_cmd, r_held_val,
                                          ecls_pkg::CNT_COMMAND, 1'b1);

    always_comb begin
        n_phase    = r_phase;
        n_held_cmd = r_held_cmd;
        n_held_val = r_held_val;
        n_is_get   = r_is_get;
        n_matched  = r_matched;
        n_answer   = r_answer;
        n_elapsed  = r_elapsed;
        o_push     = '0;

        if (i_accept) begin
            unique case (r_phase)
                PH_TX: begin
                    if (i_item.opcode == ecls_pkg::OP_DONE) begin
                        o_push.valid          = 1'b1;
                        o_push.entry.res0     = ecls_pkg::mk_res(ecls_pkg::ACT_RX, 8'd0,
                                                    8'd0, ecls_pkg::CNT_NONE, 1'b1);
                        n_elapsed             = '0;
                        n_phase               = PH_ECHO;
                    end
                end
                PH_ECHO: begin
                    if (i_item.opcode == ecls_pkg::OP_PACKET) begin
                        o_push.valid = 1'b1;
                        if (i_item.read_good &&
                            (i_item.packet_length >= ecls_pkg::MIN_ECHO_LEN)) begin
                            n_is_get  = get_now;
                            n_matched = match_now;
                            if (get_now) begin
                                n_answer = i_item.echo_second;
                            end
                            o_push.entry.res0 = ecls_pkg::mk_res(ecls_pkg::ACT_CONFIRM,
                                match_now ? ecls_pkg::CODE_OK : ecls_pkg::CODE_BAD,
                                8'd0, ecls_pkg::CNT_CONFIRM, 1'b1);
                            n_phase = PH_CONFIRM;
                        end else begin
                            // bad read or short echo: resend the command
                            o_push.entry.res0 = send_res;
                            n_phase           = PH_TX;
                        end
                    end else if (i_item.opcode == ecls_pkg::OP_TICK) begin
                        n_elapsed = elapsed_inc;
                        if (elapsed_inc >= r_timeout) begin
                            o_push.valid      = 1'b1;
                            o_push.entry.two  = 1'b1;
                            o_push.entry.res0 = ecls_pkg::mk_res(ecls_pkg::ACT_TIMEOUT,
                                r_held_cmd, r_held_val, ecls_pkg::CNT_NONE, 1'b0);
                            o_push.entry.res1 = send_res;
                            n_phase           = PH_TX;
                        end
                    end
                end
                PH_CONFIRM: begin
                    if (i_item.opcode == ecls_pkg::OP_DONE) begin
                        o_push.valid = 1'b1;
                        if (!r_matched) begin
                            o_push.entry.two  = 1'b1;
                            o_push.entry.res0 = ecls_pkg::mk_res(ecls_pkg::ACT_MISMATCH,
                                r_held_cmd, r_held_val, ecls_pkg::CNT_NONE, 1'b0);
                            o_push.entry.res1 = send_res;
                            n_phase           = PH_TX;
                        end else if (r_is_get) begin
                            o_push.entry.res0 = ecls_pkg::mk_res(ecls_pkg::ACT_GET,
                                r_held_cmd, r_answer, ecls_pkg::CNT_NONE, 1'b1);
                            n_phase           = PH_IDLE;
                        end else begin
                            o_push.entry.res0 = ecls_pkg::mk_res(ecls_pkg::ACT_ACK,
                                r_held_cmd, r_held_val, ecls_pkg::CNT_NONE, 1'b1);
                            n_phase           = PH_IDLE;
                        end
                    end
                end
                default: begin
                    // idle: latch and send a host command
                    if (i_item.opcode == ecls_pkg::OP_HOST) begin
                        n_held_cmd        = i_item.command_byte;
                        n_held_val        = i_item.value_byte;
                        o_push.valid      = 1'b1;
                        o_push.entry.res0 = ecls_pkg::mk_res(ecls_pkg::ACT_SEND,
                            i_item.command_byte, i_item.value_byte,
                            ecls_pkg::CNT_COMMAND, 1'b1);
                        n_phase           = PH_TX;
                    end
                end
            endcase

            // busy: reject host commands without touching state
            if ((i_item.opcode == ecls_pkg::OP_HOST) && (r_phase != PH_IDLE)) begin
                o_push.valid      = 1'b1;
                o_push.entry.two  = 1'b0;
                o_push.entry.res0 = ecls_pkg::mk_res(ecls_pkg::ACT_REJECT, 8'd0, 8'd0,
                                                     ecls_pkg::CNT_NONE, 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_held_cmd <= '0;
            r_held_val <= '0;
            r_is_get   <= 1'b0;
            r_matched  <= 1'b0;
            r_answer   <= '0;
            r_elapsed  <= '0;
            r_timeout  <= ecls_pkg::TIMEOUT_RESET;
        end else begin
            r_phase    <= n_phase;
            r_held_cmd <= n_held_cmd;
            r_held_val <= n_held_val;
            r_is_get   <= n_is_get;
            r_matched  <= n_matched;
            r_answer   <= n_answer;
            r_elapsed  <= n_elapsed;
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
        end
    end

    `ASSERT_IMPLY(a_pair_last, i_clk, i_rst_n, o_push.valid && o_push.entry.two, !o_push.entry.res0.last && o_push.entry.res1.last && (o_push.entry.res1.action == ecls_pkg::ACT_SEND), "two-result request has bad last flags")
    `ASSERT_NEXT(a_send_to_tx, i_clk, i_rst_n, o_push.valid && !o_push.entry.two && (o_push.entry.res0.action == ecls_pkg::ACT_SEND), r_phase == PH_TX, "send command did not enter transmitting")

endmodule

`default_nettype wire

FILE: hdl/ecls_queue.sv
// Short queue of per-request result entries between front and back.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ecls_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ecls_pkg::t_push i_push,
    input  wire logic            i_pop,
    output ecls_pkg::t_head      o_head,
    output logic                 o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ecls_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             push, pop;

    assign push         = i_push.valid;
    assign pop          = i_pop && (r_count != '0);
    assign o_full       = (r_count == FULL_CNT);
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, !(push && o_full), "push into full queue")
    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= FULL_CNT, "queue count beyond depth")

endmodule

`default_nettype wire

FILE: hdl/ecls_back.sv
// Back end: splits queued entries into single results behind an output register.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ecls_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ecls_pkg::t_head i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output ecls_pkg::t_out_item  o_out_item
);

    logic                r_out_valid, n_out_valid;
    ecls_pkg::t_out_item r_out, n_out;
    logic                r_sub, n_sub;
    logic                load;

    assign load        = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_sub       = r_sub;
        o_pop       = 1'b0;
        if (load) begin
            n_out_valid = i_head.valid;
            if (i_head.valid) begin
                n_out = r_sub ? i_head.entry.res1 : i_head.entry.res0;
                if (i_head.entry.two && !r_sub) begin
                    n_sub = 1'b1;
                end else begin
                    // last result of this entry: drop it from the queue
                    n_sub = 1'b0;
                    o_pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sub       <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_sub       <= n_sub;
        end
        r_out <= n_out;
    end

    `ASSERT_IMPLY(a_sub_pair, i_clk, i_rst_n, r_sub, i_head.valid && i_head.entry.two, "second half pending without a pair at the head")

endmodule

`default_nettype wire

FILE: hdl/echo_confirm_link_sender.sv
// Top level of the echo confirm link sender.
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries events: host
//   command, radio done, packet received and tick. A request is taken at a
//   clock edge with i_in_valid high and o_in_stall low.
//   Output channel (o_out_valid / i_out_stall / o_out_item) gives the actions
//   to perform; last marks the final result of an event. Each event gives
//   zero, one or two results.
//   Configuration: i_cfg_wr_en / i_cfg_wr_data write the echo timeout in
//   ticks; write only while the link is quiet.
// The first result of an event passes through the result queue and then the
//   output register. Throughput: one event per cycle while o_in_stall is low;
//   an event with two results gives them one at a time from the single output register.
// Reset (synchronous, active low) returns to idle, clears the result queue
//   and loads the timeout of 200 ticks.
// When the receiver stalls, results collect in a QUEUE_DEPTH entry queue;
//   o_in_stall rises only once that queue is full.
`timescale 1ns / 1ps
`default_nettype none

module echo_confirm_link_sender #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire ecls_pkg::t_in_item i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ecls_pkg::t_out_item     o_out_item,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [15:0]        i_cfg_wr_data
);

    ecls_pkg::t_push push;
    ecls_pkg::t_head head;
    logic            pop;
    logic            full;
    logic            accept;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    ecls_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_in_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (push)
    );

    ecls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full)
    );

    ecls_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
